@@ rtl/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Code page translator package
// Sizes, resolve codes and the control/status structs between the top level
// and the frame cells.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int FRAMES        = 6;
  localparam int PAGE_BITS     = 7;
  localparam int RAM_BASE_PAGE = 26;
  localparam int ADDR_BITS     = 16;

  localparam int PAGE_W = ADDR_BITS - PAGE_BITS;
  localparam int FIDX_W = $clog2(FRAMES);

  localparam int CODE_W    = 16;
  localparam int HOW_W     = 2;
  localparam int FFRAME_W  = 3;
  localparam int OUT_BITS  = CODE_W + HOW_W + FFRAME_W + CODE_W + CODE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [HOW_W-1:0] HOW_REPEAT = 2'd0;
  localparam logic [HOW_W-1:0] HOW_HIT    = 2'd1;
  localparam logic [HOW_W-1:0] HOW_MISS   = 2'd2;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic fill;       // load a new page, mark valid, clear reference
    logic touch;      // set reference bit
    logic tok_load;   // load token bit from tok_start
    logic tok_start;
    logic step;       // advance the clock hand one cell
    logic tok_in;     // token handed over by the previous cell
  } cell_ctl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic match;
    logic ref_bit;
    logic tok;
  } cell_stat_t;

endpackage

@@ rtl/cpt_cell.sv @@
// ----------------------------------------------------------------------------
// Frame cell
// Holds one resident page entry with its valid and reference bits, compares
// it against the lookup page and carries the clock-hand token around the ring.
// ----------------------------------------------------------------------------
module cpt_cell
  import cpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PAGE_W-1:0] page_i,
  input  cell_ctl_t         ctl_i,
  output cell_stat_t        stat_o
);

  logic [PAGE_W-1:0] page_q;
  logic              valid_q, valid_d;
  logic              ref_q, ref_d;
  logic              tok_q, tok_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) begin
      page_q <= page_i;
    end
  end

  always_comb begin
    valid_d = valid_q | ctl_i.fill;
    ref_d   = ref_q;
    priority if (ctl_i.fill) begin
      ref_d = 1'b0;
    end else if (ctl_i.touch) begin
      ref_d = 1'b1;
    end else if (ctl_i.step && tok_q) begin
      // second chance: clear and pass the hand on
      ref_d = 1'b0;
    end
  end

  always_comb begin
    tok_d = tok_q;
    priority if (ctl_i.tok_load) begin
      tok_d = ctl_i.tok_start;
    end else if (ctl_i.step) begin
      tok_d = ctl_i.tok_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      tok_q   <= tok_d;
    end
  end

  assign stat_o.match   = valid_q && (page_q == page_i);
  assign stat_o.ref_bit = ref_q;
  assign stat_o.tok     = tok_q;

endmodule

@@ rtl/code_page_translate_replace.sv @@
// ----------------------------------------------------------------------------
// Code page translator with page replacement
// Maps an external code address into a RAM of page frames and picks a victim
// frame on a miss.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one code address per item (tdata[15:0]). m_axis returns one
//   result per item. cfg_valid_i/cfg_data_i write replace_policy (0 round-robin,
//   1 clock second-chance); cfg_ready_o is always high. Write it only while idle.
//   An accepted item is looked up in the cycle after acceptance against the
//   last-page shortcut and, in parallel, against every frame cell. A repeat,
//   a table hit and a round-robin miss put the result in the output register
//   from the lookup state and return to idle, where the next item is taken.
//   A clock miss walks the hand through the ring of frame cells, one cell per
//   cycle, until the hand reaches a cell with its reference bit clear, which
//   becomes the victim and is filled.
//   The result register holds while m_axis_tready is low; lookup of the next
//   item waits until the register can take a new result.
//   Reset empties the table and the shortcut, clears the reference bits and
//   the pointer, and selects round-robin.
// ----------------------------------------------------------------------------
module code_page_translate_replace
  import cpt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CODE_W-1:0]      s_axis_tdata,   // code_address
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mapped_address, how_resolved, fill_frame, fill_source_base, fill_dest_base
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;

  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);

  function automatic logic [CODE_W-1:0] frame_base(input logic [FIDX_W-1:0] f);
    logic [CODE_W-1:0] pg;
    pg = CODE_W'(f) + CODE_W'(RAM_BASE_PAGE);
    return pg << PAGE_BITS;
  endfunction

  function automatic logic [FIDX_W-1:0] next_frame(input logic [FIDX_W-1:0] f);
    return (f == LAST_FRAME) ? '0 : f + FIDX_W'(1);
  endfunction

  logic [1:0]           state_q, state_d;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 policy_q;
  logic [FIDX_W-1:0]    vptr_q, vptr_d;
  logic [PAGE_W-1:0]    last_page_q, last_page_d;
  logic [FIDX_W-1:0]    last_frame_q, last_frame_d;
  logic                 last_valid_q, last_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]  out_data_q, out_data_d;

  cell_ctl_t  ctl  [FRAMES];
  cell_stat_t stat [FRAMES];

  logic [PAGE_W-1:0]    page;
  logic [PAGE_BITS-1:0] offs;
  logic                 out_free;
  logic                 any_hit, any_victim;
  logic [FIDX_W-1:0]    hit_idx, victim_idx, start_idx, fill_idx, res_frame;
  logic [FRAMES-1:0]    tok_vec;
  logic                 fill_en, touch_en, tok_load, step, emit;
  logic [HOW_W-1:0]     res_how;

  assign page          = addr_q[ADDR_BITS-1:PAGE_BITS];
  assign offs          = addr_q[PAGE_BITS-1:0];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign start_idx     = next_frame(vptr_q);

  // lowest matching frame wins; victim is the token cell with its bit clear
  always_comb begin
    any_hit    = 1'b0;
    any_victim = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      tok_vec[k] = stat[k].tok;
      if (stat[k].match) begin
        any_hit = 1'b1;
        hit_idx = FIDX_W'(k);
      end
      if (stat[k].tok && !stat[k].ref_bit) begin
        any_victim = 1'b1;
        victim_idx = FIDX_W'(k);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    vptr_d       = vptr_q;
    last_page_d  = last_page_q;
    last_frame_d = last_frame_q;
    last_valid_d = last_valid_q;
    fill_en      = 1'b0;
    touch_en     = 1'b0;
    tok_load     = 1'b0;
    step         = 1'b0;
    emit         = 1'b0;
    fill_idx     = '0;
    res_frame    = '0;
    res_how      = HOW_REPEAT;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          priority if (last_valid_q && last_page_q == page) begin
            emit      = 1'b1;
            res_frame = last_frame_q;
            res_how   = HOW_REPEAT;
            state_d   = ST_IDLE;
          end else if (any_hit) begin
            emit      = 1'b1;
            touch_en  = 1'b1;
            res_frame = hit_idx;
            res_how   = HOW_HIT;
            state_d   = ST_IDLE;
          end else if (!policy_q) begin
            emit      = 1'b1;
            fill_en   = 1'b1;
            fill_idx  = vptr_q;
            res_frame = vptr_q;
            res_how   = HOW_MISS;
            vptr_d    = next_frame(vptr_q);
            state_d   = ST_IDLE;
          end else begin
            // start the clock hand one past the pointer
            tok_load = 1'b1;
            state_d  = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (any_victim) begin
          if (out_free) begin
            emit      = 1'b1;
            fill_en   = 1'b1;
            tok_load  = 1'b1;
            fill_idx  = victim_idx;
            res_frame = victim_idx;
            res_how   = HOW_MISS;
            vptr_d    = victim_idx;
            state_d   = ST_IDLE;
          end
        end else begin
          step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (emit) begin
      last_page_d  = page;
      last_frame_d = res_frame;
      last_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (res_how == HOW_MISS) begin
        out_data_d = {frame_base(res_frame),
                      CODE_W'({page, {PAGE_BITS{1'b0}}}),
                      FFRAME_W'(res_frame),
                      res_how,
                      frame_base(res_frame) + CODE_W'(offs)};
      end else begin
        out_data_d = {{(2 * CODE_W + FFRAME_W){1'b0}},
                      res_how,
                      frame_base(res_frame) + CODE_W'(offs)};
      end
    end
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    localparam int PREV = (k == 0) ? FRAMES - 1 : k - 1;

    assign ctl[k].fill      = fill_en && (fill_idx == FIDX_W'(k));
    assign ctl[k].touch     = touch_en && (hit_idx == FIDX_W'(k));
    assign ctl[k].tok_load  = tok_load;
    assign ctl[k].tok_start = (state_q == ST_LOOKUP) && (start_idx == FIDX_W'(k));
    assign ctl[k].step      = step;
    assign ctl[k].tok_in    = stat[PREV].tok && stat[PREV].ref_bit;

    cpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .page_i (page),
      .ctl_i  (ctl[k]),
      .stat_o (stat[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      addr_q <= s_axis_tdata[ADDR_BITS-1:0];
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      policy_q     <= 1'b0;
      vptr_q       <= '0;
      last_page_q  <= '0;
      last_frame_q <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      vptr_q       <= vptr_d;
      last_page_q  <= last_page_d;
      last_frame_q <= last_frame_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

`ifndef SYNTHESIS
  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one clock hand in the ring");

  a_tok_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> $onehot(tok_vec))
    else $error("sweep without a clock hand");

  a_vptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vptr_q <= LAST_FRAME)
    else $error("victim pointer out of range");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_LOOKUP))
    else $error("accepted item not looked up");
`endif

endmodule
